FILE: sv/sfpd_pkg.sv
// sfpd_pkg: shared types and constants for the sensor frame parser / PWM drive.
// Holds the word structs, header bytes, register indexes and parser states.
// No dependencies.
`default_nettype none

package sfpd_pkg;

  localparam int FRAME_BYTES_DEF  = 32;
  localparam int TICKS_PER_MS_DEF = 10;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_INDEX_W      = 2;
  localparam int HDR_LEN          = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_PWM_ENABLE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_TMO_MS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD  = 2'd2;

  localparam logic       RST_PWM_ENABLE = 1'b1;
  localparam logic [7:0] RST_BYTE_TMO   = 8'd5;
  localparam logic [15:0] RST_PWM_PERIOD = 16'd100;
  localparam logic [15:0] RST_DUTY       = 16'd50;

  localparam logic [7:0] HEADER [HDR_LEN] = '{8'h42, 8'h4d, 8'h00, 8'h1c};

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    PS_HUNT0 = 3'd0,
    PS_HUNT1 = 3'd1,
    PS_HUNT2 = 3'd2,
    PS_HUNT3 = 3'd3,
    PS_BODY  = 3'd4
  } parse_step_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic       gate_pin;
  } in_word_t;

  typedef struct packed {
    logic        pwm_out;
    logic        frame_done;
    logic [15:0] duty_value;
  } out_word_t;

  // Classified word as it sits in the queue.
  typedef struct packed {
    in_word_t           word;
    logic [HDR_LEN-1:0] hdr_hit;
  } cls_word_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: sv/sfpd_front.sv
// sfpd_front: input stage; registers each accepted word and tags header matches.
// Depends on sfpd_pkg.
`default_nettype none

module sfpd_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sfpd_pkg::in_word_t  in_data,
  input  wire sfpd_pkg::q_status_t q_stat,
  output logic                     push,
  output sfpd_pkg::cls_word_t      push_data
);

  logic                valid_r, valid_nxt;
  sfpd_pkg::cls_word_t hold_r, hold_nxt;
  logic                take;

  assign in_stall  = valid_r && q_stat.full;
  assign take      = in_valid && !in_stall;
  assign push      = valid_r && !q_stat.full;
  assign push_data = hold_r;

  always_comb begin
    valid_nxt = valid_r;
    hold_nxt  = hold_r;
    if (push) valid_nxt = 1'b0;
    if (take) begin
      valid_nxt         = 1'b1;
      hold_nxt.word     = in_data;
      for (int i = 0; i < sfpd_pkg::HDR_LEN; i++) begin
        hold_nxt.hdr_hit[i] = (in_data.rx_byte == sfpd_pkg::HEADER[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/sfpd_queue.sv
// sfpd_queue: two-entry queue between the front and back stages.
// Depends on sfpd_pkg.
`default_nettype none

module sfpd_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire sfpd_pkg::cls_word_t push_data,
  input  wire logic                pop,
  output sfpd_pkg::cls_word_t      head,
  output sfpd_pkg::q_status_t      q_stat
);

  sfpd_pkg::cls_word_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

FILE: sv/sfpd_back.sv
// sfpd_back: executes queued words: frame parser, timeout, PWM counter, result register.
// Depends on sfpd_pkg.
`default_nettype none

module sfpd_back #(
  parameter int FRAME_BYTES  = sfpd_pkg::FRAME_BYTES_DEF,
  parameter int TICKS_PER_MS = sfpd_pkg::TICKS_PER_MS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [sfpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [sfpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire sfpd_pkg::cls_word_t               head,
  input  wire sfpd_pkg::q_status_t               q_stat,
  output logic                                   pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output sfpd_pkg::out_word_t                    out_data
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int DIV_W = $clog2(TICKS_PER_MS + 1);

  // configuration
  logic        pwm_enable_r;
  logic [7:0]  byte_tmo_r;
  logic [15:0] pwm_period_r;

  // state
  sfpd_pkg::parse_step_t step_r, step_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       duty_high_r, duty_high_nxt;
  logic [7:0]       duty_low_r, duty_low_nxt;
  logic [15:0]      duty_r, duty_nxt;
  logic [15:0]      pwm_count_r, pwm_count_nxt;
  logic [DIV_W-1:0] tick_div_r, tick_div_nxt;
  logic [7:0]       tmo_left_r, tmo_left_nxt;
  logic             level_r, level_nxt;
  logic             out_valid_r, out_valid_nxt;
  sfpd_pkg::out_word_t out_data_r, out_data_nxt;

  logic             is_byte, is_tick, hit, body_end, ms_roll, restart_tick, wrap, done;
  logic [CNT_W-1:0] cnt_inc;
  logic [DIV_W-1:0] div_inc;
  logic [16:0]      pwm_inc;

  assign pop       = !q_stat.empty && (!out_valid_r || !out_stall);
  assign is_byte   = pop && (head.word.kind == sfpd_pkg::KIND_BYTE);
  assign is_tick   = pop && (head.word.kind == sfpd_pkg::KIND_TICK);
  assign cnt_inc   = byte_count_r + CNT_W'(1);
  assign body_end  = (cnt_inc >= CNT_W'(FRAME_BYTES));
  assign div_inc   = tick_div_r + DIV_W'(1);
  assign ms_roll   = (div_inc >= DIV_W'(TICKS_PER_MS));
  assign restart_tick = is_tick && ms_roll && (tmo_left_r == 8'd0);
  assign pwm_inc   = {1'b0, pwm_count_r} + 17'd1;
  assign wrap      = (pwm_inc >= {1'b0, pwm_period_r});
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (step_r)
      sfpd_pkg::PS_HUNT0: hit = head.hdr_hit[0];
      sfpd_pkg::PS_HUNT1: hit = head.hdr_hit[1];
      sfpd_pkg::PS_HUNT2: hit = head.hdr_hit[2];
      sfpd_pkg::PS_HUNT3: hit = head.hdr_hit[3];
      default:            hit = 1'b0;
    endcase
  end

  // next parser state
  always_comb begin
    step_nxt = step_r;
    if (restart_tick) begin
      step_nxt = sfpd_pkg::PS_HUNT0;
    end else if (is_byte) begin
      case (step_r)
        sfpd_pkg::PS_HUNT0: step_nxt = hit ? sfpd_pkg::PS_HUNT1 : sfpd_pkg::PS_HUNT0;
        sfpd_pkg::PS_HUNT1: step_nxt = hit ? sfpd_pkg::PS_HUNT2 : sfpd_pkg::PS_HUNT0;
        sfpd_pkg::PS_HUNT2: step_nxt = hit ? sfpd_pkg::PS_HUNT3 : sfpd_pkg::PS_HUNT0;
        sfpd_pkg::PS_HUNT3: step_nxt = hit ? sfpd_pkg::PS_BODY  : sfpd_pkg::PS_HUNT0;
        sfpd_pkg::PS_BODY:  step_nxt = body_end ? sfpd_pkg::PS_HUNT0 : sfpd_pkg::PS_BODY;
        default:            step_nxt = sfpd_pkg::PS_HUNT0;
      endcase
    end
  end

  // parser datapath and PWM
  always_comb begin
    byte_count_nxt = byte_count_r;
    duty_high_nxt  = duty_high_r;
    duty_low_nxt   = duty_low_r;
    duty_nxt       = duty_r;
    pwm_count_nxt  = pwm_count_r;
    tick_div_nxt   = tick_div_r;
    tmo_left_nxt   = tmo_left_r;
    level_nxt      = level_r;
    done           = 1'b0;

    if (is_byte) begin
      tmo_left_nxt = byte_tmo_r;
      case (step_r)
        sfpd_pkg::PS_HUNT0, sfpd_pkg::PS_HUNT1, sfpd_pkg::PS_HUNT2, sfpd_pkg::PS_HUNT3: begin
          byte_count_nxt = hit ? cnt_inc : '0;
        end
        sfpd_pkg::PS_BODY: begin
          if (byte_count_r == CNT_W'(6)) duty_high_nxt = head.word.rx_byte;
          if (byte_count_r == CNT_W'(7)) duty_low_nxt  = head.word.rx_byte;
          byte_count_nxt = cnt_inc;
          if (body_end) begin
            duty_nxt       = {duty_high_nxt, duty_low_nxt};
            done           = 1'b1;
            byte_count_nxt = '0;
          end
        end
        default: byte_count_nxt = '0;
      endcase
    end

    if (is_tick) begin
      if (wrap) begin
        pwm_count_nxt = '0;
        level_nxt     = pwm_enable_r;
      end else begin
        pwm_count_nxt = pwm_inc[15:0];
      end
      if ((pwm_count_nxt >= duty_r) && head.word.gate_pin) level_nxt = 1'b0;
      if (ms_roll) begin
        tick_div_nxt = '0;
        if (tmo_left_r != 8'd0) tmo_left_nxt = tmo_left_r - 8'd1;
        else                    byte_count_nxt = '0;
      end else begin
        tick_div_nxt = div_inc;
      end
    end
  end

  // result register: load on pop, drop when taken downstream
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (pop) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.pwm_out    = level_nxt;
      out_data_nxt.frame_done = done;
      out_data_nxt.duty_value = duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_enable_r <= sfpd_pkg::RST_PWM_ENABLE;
      byte_tmo_r   <= sfpd_pkg::RST_BYTE_TMO;
      pwm_period_r <= sfpd_pkg::RST_PWM_PERIOD;
      step_r       <= sfpd_pkg::PS_HUNT0;
      byte_count_r <= '0;
      duty_high_r  <= '0;
      duty_low_r   <= '0;
      duty_r       <= sfpd_pkg::RST_DUTY;
      pwm_count_r  <= '0;
      tick_div_r   <= '0;
      tmo_left_r   <= '0;
      level_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sfpd_pkg::CFG_PWM_ENABLE:  pwm_enable_r <= cfg_data[0];
          sfpd_pkg::CFG_BYTE_TMO_MS: byte_tmo_r   <= cfg_data[7:0];
          sfpd_pkg::CFG_PWM_PERIOD:  pwm_period_r <= cfg_data;
          default: ;
        endcase
      end
      step_r       <= step_nxt;
      byte_count_r <= byte_count_nxt;
      duty_high_r  <= duty_high_nxt;
      duty_low_r   <= duty_low_nxt;
      duty_r       <= duty_nxt;
      pwm_count_r  <= pwm_count_nxt;
      tick_div_r   <= tick_div_nxt;
      tmo_left_r   <= tmo_left_nxt;
      level_r      <= level_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/sensor_frame_pwm_drive.sv
// sensor_frame_pwm_drive: particle-sensor frame parser driving a PWM output.
// Each accepted word is held in the front register, then in a queue slot, then
// in the result register.
// Throughput: one word per cycle while neither in_stall nor out_stall holds the flow.
// Reset (rst_n low, synchronous): queue and result register empty, registers at
// their defaults (enable 1, timeout 5 ms, period 100), duty 50, parser hunting.
// Depends on sfpd_pkg, sfpd_front, sfpd_queue, sfpd_back.
`default_nettype none

module sensor_frame_pwm_drive #(
  parameter int FRAME_BYTES  = sfpd_pkg::FRAME_BYTES_DEF,
  parameter int TICKS_PER_MS = sfpd_pkg::TICKS_PER_MS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input words: received bytes and 0.1 ms ticks
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire sfpd_pkg::in_word_t               in_data,
  // result words, one per input word
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output sfpd_pkg::out_word_t                   out_data,
  // register writes
  input  wire logic                             cfg_we,
  input  wire logic [sfpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sfpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sfpd_pkg::q_status_t q_stat;
  sfpd_pkg::cls_word_t push_data;
  sfpd_pkg::cls_word_t head;
  logic                push;
  logic                pop;

  // Front: hold the accepted word and tag which header byte it matches.
  sfpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Queue: decouple front stalls from result-side stalls.
  sfpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Back: advance parser, timeout and PWM counter; register the result word.
  sfpd_back #(
    .FRAME_BYTES  (FRAME_BYTES),
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/sv/sensor_frame_pwm_drive_tb.sv
`timescale 1ns / 100ps
// sensor_frame_pwm_drive_tb: self-checking bench for the sensor frame parser and PWM drive.
// Tracks parser, timeout and PWM state alongside the block and checks every result word.
// Depends on sfpd_pkg and sensor_frame_pwm_drive.

module sensor_frame_pwm_drive_tb;

  localparam int          ITEMS_PER_PHASE = 250;
  localparam int          PHASES          = 6;
  localparam int          RESET_CYCLES    = 12;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT     = 1000000;

  // particle-sensor frame header, in order
  localparam logic [7:0] SYNC_0 = 8'h42;
  localparam logic [7:0] SYNC_1 = 8'h4d;
  localparam logic [7:0] SYNC_2 = 8'h00;
  localparam logic [7:0] SYNC_3 = 8'h1c;

  // frame positions that carry the duty, big-endian
  localparam int DUTY_HI_POS = 6;
  localparam int DUTY_LO_POS = 7;

  // short local names for the word kinds and the duty after reset
  localparam logic        IS_BYTE = sfpd_pkg::KIND_BYTE;
  localparam logic        IS_TICK = sfpd_pkg::KIND_TICK;
  localparam logic [15:0] DUTY0   = sfpd_pkg::RST_DUTY;

  typedef struct packed {
    sfpd_pkg::in_word_t  word;
    logic                typed;   // want below is typed in by hand
    sfpd_pkg::out_word_t want;
  } plan_row_t;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  sfpd_pkg::in_word_t               in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  sfpd_pkg::out_word_t              out_data;
  logic                             cfg_we    = 1'b0;
  logic [sfpd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sfpd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  sensor_frame_pwm_drive dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copies and parser / PWM state.
  // ---------------------------------------------------------------------------
  logic        reg_enable;
  logic [7:0]  reg_timeout;
  logic [15:0] reg_period;

  sfpd_pkg::parse_step_t hunt_step;
  logic [5:0]  frame_pos;
  logic [7:0]  duty_hi_byte;
  logic [7:0]  duty_lo_byte;
  logic [15:0] duty_now;
  logic [15:0] pwm_cnt;
  logic [3:0]  ms_div;
  logic [7:0]  silence_left;
  logic        pwm_lvl;

  sfpd_pkg::out_word_t want_words [$];   // result words still owed, oldest first
  sfpd_pkg::in_word_t  burst [$];        // words of the sequence being built
  int          fail_count  = 0;
  int          phase_items = 0;
  logic        sender_quiet = 1'b0;

  task automatic reset_shadow();
    reg_enable   = sfpd_pkg::RST_PWM_ENABLE;
    reg_timeout  = sfpd_pkg::RST_BYTE_TMO;
    reg_period   = sfpd_pkg::RST_PWM_PERIOD;
    hunt_step    = sfpd_pkg::PS_HUNT0;
    frame_pos    = '0;
    duty_hi_byte = '0;
    duty_lo_byte = '0;
    duty_now     = sfpd_pkg::RST_DUTY;
    pwm_cnt      = '0;
    ms_div       = '0;
    silence_left = '0;
    pwm_lvl      = 1'b0;
  endtask

  function automatic logic [7:0] sync_byte(sfpd_pkg::parse_step_t s);
    case (s)
      sfpd_pkg::PS_HUNT0: return SYNC_0;
      sfpd_pkg::PS_HUNT1: return SYNC_1;
      sfpd_pkg::PS_HUNT2: return SYNC_2;
      default:            return SYNC_3;
    endcase
  endfunction

  // Advance the shadow by one word and return the result word it must produce.
  function automatic sfpd_pkg::out_word_t next_drive_word(sfpd_pkg::in_word_t w);
    sfpd_pkg::out_word_t r;
    logic [16:0]         bumped;
    logic                done;
    done = 1'b0;
    if (w.kind == sfpd_pkg::KIND_BYTE) begin
      // any byte reloads the inter-byte timeout
      silence_left = reg_timeout;
      if (hunt_step != sfpd_pkg::PS_BODY) begin
        if (w.rx_byte == sync_byte(hunt_step)) begin
          frame_pos = frame_pos + 6'd1;
          hunt_step = sfpd_pkg::parse_step_t'(hunt_step + 3'd1);
        end else begin
          // drop the byte and hunt from the first header byte again
          hunt_step = sfpd_pkg::PS_HUNT0;
          frame_pos = '0;
        end
      end else begin
        if (frame_pos == DUTY_HI_POS)
          duty_hi_byte = w.rx_byte;
        else if (frame_pos == DUTY_LO_POS)
          duty_lo_byte = w.rx_byte;
        frame_pos = frame_pos + 6'd1;
        if (frame_pos >= sfpd_pkg::FRAME_BYTES_DEF) begin
          duty_now  = {duty_hi_byte, duty_lo_byte};
          done      = 1'b1;
          hunt_step = sfpd_pkg::PS_HUNT0;
          frame_pos = '0;
        end
      end
    end else begin
      // a period of zero behaves like one: the compare always wraps
      bumped = {1'b0, pwm_cnt} + 17'd1;
      if (bumped >= {1'b0, reg_period}) begin
        pwm_cnt = '0;
        pwm_lvl = reg_enable;
      end else begin
        pwm_cnt = bumped[15:0];
      end
      if (pwm_cnt >= duty_now && w.gate_pin)
        pwm_lvl = 1'b0;
      ms_div = ms_div + 4'd1;
      if (ms_div >= sfpd_pkg::TICKS_PER_MS_DEF) begin
        ms_div = '0;
        if (silence_left != 0) begin
          silence_left = silence_left - 8'd1;
        end else begin
          hunt_step = sfpd_pkg::PS_HUNT0;
          frame_pos = '0;
        end
      end
    end
    r.pwm_out    = pwm_lvl;
    r.frame_done = done;
    r.duty_value = duty_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, then compare each accepted word with the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int stall_pick;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 40) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(1, 12);
      end else if (stall_pick < 50) begin
        // long stretch with no back-pressure at all
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(60, 200);
      end else if (stall_pick < 90) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(1, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  sfpd_pkg::out_word_t oldest;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (want_words.size() == 0) begin
        $error("result word with nothing expected: pwm_out=%0b frame_done=%0b duty_value=%0d",
               out_data.pwm_out, out_data.frame_done, out_data.duty_value);
        fail_count++;
      end else begin
        oldest = want_words.pop_front();
        if (out_data.pwm_out !== oldest.pwm_out) begin
          $error("pwm_out: expected %0b, got %0b", oldest.pwm_out, out_data.pwm_out);
          fail_count++;
        end
        if (out_data.frame_done !== oldest.frame_done) begin
          $error("frame_done: expected %0b, got %0b", oldest.frame_done, out_data.frame_done);
          fail_count++;
        end
        if (out_data.duty_value !== oldest.duty_value) begin
          $error("duty_value: expected %0d, got %0d", oldest.duty_value, out_data.duty_value);
          fail_count++;
        end
      end
    end
  end

  // Hard stop in case the block hangs or drops a word.
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then record what it must produce.
  // Hand-typed rows override the shadow's answer but still advance the shadow.
  task automatic send_word(sfpd_pkg::in_word_t w, logic typed, sfpd_pkg::out_word_t want);
    int                  gap;
    int                  pick;
    sfpd_pkg::out_word_t predicted;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (!sender_quiet) begin
      if (pick >= 90)
        gap = $urandom_range(8, 30);
      else if (pick >= 55)
        gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predicted = next_drive_word(w);
    want_words.push_back(typed ? want : predicted);
    phase_items++;
  endtask

  // Hold the sender off until every owed result word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (want_words.size() != 0) @(posedge clk);
  endtask

  // Write all three registers on back-to-back edges; the enable and timeout writes carry
  // junk in upper data bits that the block must ignore.
  task automatic write_settings(logic en, logic [7:0] tmo, logic [15:0] per);
    cfg_we    <= 1'b1;
    cfg_index <= sfpd_pkg::CFG_PWM_ENABLE;
    cfg_data  <= {15'($urandom_range(0, 32767)), en};
    @(posedge clk);
    cfg_index <= sfpd_pkg::CFG_BYTE_TMO_MS;
    cfg_data  <= {8'($urandom_range(0, 255)), tmo};
    @(posedge clk);
    cfg_index <= sfpd_pkg::CFG_PWM_PERIOD;
    cfg_data  <= per;
    @(posedge clk);
    cfg_we      <= 1'b0;
    reg_enable  = en;
    reg_timeout = tmo;
    reg_period  = per;
  endtask

  task automatic add_byte(logic [7:0] b);
    sfpd_pkg::in_word_t w;
    w.kind     = sfpd_pkg::KIND_BYTE;
    w.rx_byte  = b;
    w.gate_pin = 1'($urandom_range(0, 1));
    burst.push_back(w);
  endtask

  // rx_byte is don't-care on ticks; fill it with noise anyway
  task automatic add_tick();
    sfpd_pkg::in_word_t w;
    w.kind     = sfpd_pkg::KIND_TICK;
    w.rx_byte  = 8'($urandom_range(0, 255));
    w.gate_pin = 1'($urandom_range(0, 1));
    burst.push_back(w);
  endtask

  // Enough silent ticks to run the inter-byte timeout out at small settings.
  function automatic int timeout_run();
    if (reg_timeout <= 10)
      return (reg_timeout + 2) * sfpd_pkg::TICKS_PER_MS_DEF + $urandom_range(0, 5);
    return $urandom_range(1, 20);
  endfunction

  task automatic queue_ticks(int n);
    repeat (n) add_tick();
  endtask

  // Well-formed frame with a few ticks sprinkled between bytes (never enough to
  // time out). Duty leans toward values inside the current period.
  task automatic queue_frame();
    logic [15:0] dval;
    logic [7:0]  b;
    int          i;
    if ($urandom_range(0, 1)) begin
      dval = 16'($urandom_range(0, reg_period + 2));
    end else begin
      case ($urandom_range(0, 3))
        0:       dval = 16'h0000;
        1:       dval = 16'hffff;
        default: dval = 16'($urandom_range(0, 65535));
      endcase
    end
    for (i = 0; i < sfpd_pkg::FRAME_BYTES_DEF; i++) begin
      if ($urandom_range(0, 99) < 30)
        queue_ticks($urandom_range(1, 3));
      if (i < sfpd_pkg::HDR_LEN)
        b = sync_byte(sfpd_pkg::parse_step_t'(i));
      else if (i == DUTY_HI_POS)
        b = dval[15:8];
      else if (i == DUTY_LO_POS)
        b = dval[7:0];
      else
        b = 8'($urandom_range(0, 255));
      add_byte(b);
    end
  endtask

  // Either a header broken after a good prefix, or a frame cut off and followed by silent
  // ticks, which time it out at small timeout settings (duty must stay put).
  task automatic queue_broken();
    int         k;
    int         i;
    logic [7:0] b;
    if ($urandom_range(0, 1)) begin
      k = $urandom_range(1, sfpd_pkg::HDR_LEN - 1);
      for (i = 0; i < k; i++)
        add_byte(sync_byte(sfpd_pkg::parse_step_t'(i)));
      // a repeated first header byte is still a mismatch here
      if ($urandom_range(0, 99) < 30) begin
        b = SYNC_0;
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == sync_byte(sfpd_pkg::parse_step_t'(k)))
          b = b ^ 8'h01;
      end
      add_byte(b);
    end else begin
      k = $urandom_range(0, sfpd_pkg::FRAME_BYTES_DEF - sfpd_pkg::HDR_LEN - 1);
      for (i = 0; i < sfpd_pkg::HDR_LEN; i++)
        add_byte(sync_byte(sfpd_pkg::parse_step_t'(i)));
      repeat (k) add_byte(8'($urandom_range(0, 255)));
      queue_ticks(timeout_run());
    end
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 2) == 0)
        add_tick();
      else if ($urandom_range(0, 4) == 0)
        add_byte(sync_byte(sfpd_pkg::parse_step_t'($urandom_range(0, sfpd_pkg::HDR_LEN - 1))));
      else
        add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  function automatic plan_row_t plan_row(logic kind, logic [7:0] b, logic g, logic typed,
                                         logic lvl, logic done, logic [15:0] duty);
    plan_row_t r;
    r.word.kind       = kind;
    r.word.rx_byte    = b;
    r.word.gate_pin   = g;
    r.typed           = typed;
    r.want.pwm_out    = lvl;
    r.want.frame_done = done;
    r.want.duty_value = duty;
    return r;
  endfunction

  initial begin : stimulus
    plan_row_t          plan [$];
    sfpd_pkg::in_word_t w;
    int                 phase;
    int                 pick;
    logic               paused;

    reset_shadow();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset settings. Hand-typed answers only where the
    // parser sits in the hunt and the PWM count is still far below the duty.
    plan.push_back(plan_row(IS_BYTE, SYNC_0, 1'b0, 1'b1, 1'b0, 1'b0, DUTY0));
    // second 0x42 breaks the header and is itself dropped
    plan.push_back(plan_row(IS_BYTE, SYNC_0, 1'b1, 1'b1, 1'b0, 1'b0, DUTY0));
    plan.push_back(plan_row(IS_BYTE, SYNC_0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_BYTE, SYNC_1, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_BYTE, SYNC_2, 1'b1, 1'b0, 1'b0, 1'b0, '0));
    // wrong last header byte, then a stray byte while hunting
    plan.push_back(plan_row(IS_BYTE, 8'hff,  1'b0, 1'b1, 1'b0, 1'b0, DUTY0));
    plan.push_back(plan_row(IS_BYTE, 8'h00,  1'b1, 1'b1, 1'b0, 1'b0, DUTY0));
    plan.push_back(plan_row(IS_TICK, 8'h00,  1'b1, 1'b1, 1'b0, 1'b0, DUTY0));
    plan.push_back(plan_row(IS_TICK, 8'hff,  1'b0, 1'b1, 1'b0, 1'b0, DUTY0));
    plan.push_back(plan_row(IS_BYTE, 8'hff,  1'b1, 1'b1, 1'b0, 1'b0, DUTY0));
    // full header, then the start of a body including both duty bytes
    plan.push_back(plan_row(IS_BYTE, SYNC_0, 1'b1, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_BYTE, SYNC_1, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_BYTE, SYNC_2, 1'b1, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_BYTE, SYNC_3, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_BYTE, 8'h00,  1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_BYTE, 8'hff,  1'b1, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_BYTE, 8'h00,  1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_BYTE, 8'h0a,  1'b1, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_TICK, 8'h5a,  1'b1, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_TICK, 8'ha5,  1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_TICK, 8'h00,  1'b1, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_BYTE, 8'hff,  1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_TICK, 8'hff,  1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(IS_BYTE, 8'h55,  1'b1, 1'b0, 1'b0, 1'b0, '0));
    foreach (plan[i])
      send_word(plan[i].word, plan[i].typed, plan[i].want);

    // Random phases, each under its own register settings. Extremes first,
    // then a short period right after the longest so the count sits above it,
    // then a zero period.
    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       write_settings(1'b1, 8'd1, 16'd1);
        1:       write_settings(1'b0, 8'd255, 16'd65535);
        2:       write_settings(1'b1, 8'd4, 16'd37);
        3:       write_settings(1'b1, 8'd2, 16'd0);
        4:       write_settings(1'($urandom_range(0, 1)), 8'($urandom_range(1, 8)),
                                16'($urandom_range(8, 300)));
        default: write_settings(1'b1, 8'd3, 16'd120);
      endcase
      phase_items = 0;
      paused      = 1'b0;
      while (phase_items < ITEMS_PER_PHASE) begin
        // halfway through, let the pipe run completely dry once
        if (!paused && phase_items >= ITEMS_PER_PHASE / 2) begin
          drain_results();
          paused = 1'b1;
        end
        sender_quiet = ($urandom_range(0, 99) < 20);
        pick         = $urandom_range(0, 99);
        if (pick < 55)
          queue_frame();
        else if (pick < 70)
          queue_ticks(($urandom_range(0, 9) == 0) ? timeout_run() : $urandom_range(1, 25));
        else if (pick < 85)
          queue_broken();
        else
          queue_noise();
        while (burst.size() != 0) begin
          w = burst.pop_front();
          send_word(w, 1'b0, '0);
        end
      end
    end

    // Wait for every owed word, then let the clock run on to catch strays.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
